[rtl/core/edp_pkg.sv]
`timescale 1ns / 1ps

package edp_pkg;

  // adc and rail limits
  localparam int ADC_MAX   = 1023;
  localparam int ADC_W     = 10;
  localparam int LO_RAIL   = ADC_MAX / 10;
  localparam int HI_RAIL   = ADC_MAX * 9 / 10;
  localparam int HALF      = ADC_MAX / 2;
  localparam int LOW_LIMIT = 100;

  // register widths and reset values
  localparam int FS_W   = 16;
  localparam int HYST_W = 15;
  localparam logic [FS_W-1:0]   FS_MIN         = FS_W'(2);
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = FS_W'(1024);
  localparam logic [HYST_W-1:0] HYST_RST       = HYST_W'(4);

  // calibration and scaling widths
  localparam int RL_W    = 7;
  localparam int SPAN_W  = ADC_W + 1;
  localparam int BAND_W  = 7;
  localparam int RECIP_W = 13;
  localparam int BAND_RECIP  = 6554;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W  = FS_W + ADC_W + 1;
  localparam int QUOT_W  = 17;
  localparam int REM_W   = SPAN_W;
  localparam int CNT_W   = 5;
  localparam int DIV_STEPS = QUOT_W;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic REG_HYSTERESIS = 1'b1;

  typedef struct packed {
    logic load;
    logic cal;
    logic start_a;
    logic take_a;
    logic start_b;
    logic take_b;
    logic sel;
    logic finish;
  } edp_cmd_t;

  typedef struct packed {
    logic calibrated;
    logic div_done;
    logic out_busy;
  } edp_stat_t;

endpackage

[rtl/core/edp_if.sv]
`timescale 1ns / 1ps

interface edp_in_if import edp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] phase_a;
  logic [ADC_W-1:0] phase_b;

  modport source (output valid, output phase_a, output phase_b, input ready);
  modport sink (input valid, input phase_a, input phase_b, output ready);
endinterface

interface edp_out_if import edp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FS_W-1:0] position;
  logic            changed;
  logic            calibrated;

  modport source (output valid, output position, output changed, output calibrated,
                  input ready);
  modport sink (input valid, input position, input changed, input calibrated,
                output ready);
endinterface

[rtl/core/edp_div.sv]
`timescale 1ns / 1ps

module edp_div import edp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [SPAN_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  logic [REM_W-1:0]  rem;
  logic [QUOT_W-1:0] quo;
  logic [SPAN_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W:0]    shifted;
  logic [REM_W:0]    diff;
  logic              fits;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem, quo[QUOT_W-1]};
    fits    = shifted >= {1'b0, dsr};
    diff    = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // upper dividend bits are always below the divisor, so the quotient fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {{(REM_W - PROD_W + QUOT_W){1'b0}}, dividend[PROD_W-1:QUOT_W]};
      quo <= dividend[QUOT_W-1:0];
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      quo <= {quo[QUOT_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[rtl/core/edp_datapath.sv]
`timescale 1ns / 1ps

module edp_datapath import edp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  edp_cmd_t          cmd,
  output edp_stat_t         stat,
  input  logic [ADC_W-1:0]  phase_a,
  input  logic [ADC_W-1:0]  phase_b,
  input  logic [FS_W-1:0]   full_scale,
  input  logic [HYST_W-1:0] hysteresis,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [FS_W-1:0]   position,
  output logic              changed,
  output logic              calibrated
);

  logic [ADC_W-1:0]  pa;
  logic [ADC_W-1:0]  pb;
  logic [RL_W-1:0]   rl;
  logic [SPAN_W-1:0] span;
  logic              cal;
  logic [BAND_W-1:0] band;
  logic [FS_W-1:0]   held;
  logic [FS_W-1:0]   v1;
  logic [FS_W-1:0]   v2;
  logic [FS_W-1:0]   vsel;

  logic [FS_W-1:0]             fs_eff;
  logic [ADC_W-1:0]            delta;
  logic [ADC_W-1:0]            delta_low;
  logic                        cal_ok;
  logic [ADC_W-1:0]            phase_pick;
  logic [PROD_W-1:0]           dividend;
  logic [SPAN_W+RECIP_W-1:0]   band_prod;
  logic                        div_done;
  logic [QUOT_W-1:0]           quot;
  logic [FS_W-1:0]             q_sat;
  logic [FS_W:0]               v2_sum;
  logic [FS_W-1:0]             v2_wrap;
  logic [FS_W:0]               avg_sum;
  logic [FS_W-1:0]             avg;
  logic [FS_W-1:0]             avg_wrap;
  logic [ADC_W-1:0]            dist_a;
  logic [ADC_W-1:0]            dist_b;
  logic [FS_W-1:0]             sel_v;
  logic [FS_W-1:0]             hyst_diff;
  logic                        upd;

  always_comb begin
    fs_eff    = (full_scale < FS_MIN) ? FS_MIN : full_scale;
    delta     = (pa >= pb) ? pa - pb : pb - pa;
    delta_low = delta - ADC_W'(HALF);
    cal_ok    = (pa >= ADC_W'(LO_RAIL)) && (pa <= ADC_W'(HI_RAIL)) &&
                (pb >= ADC_W'(LO_RAIL)) && (pb <= ADC_W'(HI_RAIL)) &&
                (delta >= ADC_W'(HALF)) && (delta_low <= ADC_W'(LOW_LIMIT));

    phase_pick = cmd.start_b ? pb : pa;
    dividend   = PROD_W'(fs_eff) *
                 (PROD_W'(phase_pick) + PROD_W'(rl));
    band_prod  = (SPAN_W+RECIP_W)'(span) * (SPAN_W+RECIP_W)'(BAND_RECIP);

    q_sat   = (|quot[QUOT_W-1:FS_W]) ? '1 : quot[FS_W-1:0];
    // half-turn shift, sum stays below two turns
    v2_sum  = {1'b0, q_sat} + {2'b00, fs_eff[FS_W-1:1]};
    v2_wrap = (v2_sum >= {1'b0, fs_eff}) ? FS_W'(v2_sum - {1'b0, fs_eff})
                                         : v2_sum[FS_W-1:0];

    avg_sum  = {1'b0, v1} + {1'b0, v2};
    avg      = avg_sum[FS_W:1];
    avg_wrap = (avg >= fs_eff) ? avg - fs_eff : avg;

    dist_a = (pa >= ADC_W'(HALF)) ? pa - ADC_W'(HALF) : ADC_W'(HALF) - pa;
    dist_b = (pb >= ADC_W'(HALF)) ? pb - ADC_W'(HALF) : ADC_W'(HALF) - pb;
    if (dist_a < ADC_W'(band)) begin
      sel_v = v1;
    end else if (dist_b < ADC_W'(band)) begin
      sel_v = v2;
    end else begin
      sel_v = avg_wrap;
    end

    hyst_diff = (vsel >= held) ? vsel - held : held - vsel;
    upd       = cal && (hyst_diff > {1'b0, hysteresis});
  end

  edp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_a | cmd.start_b),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal       <= 1'b0;
      rl        <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cal && !cal && cal_ok) begin
        cal <= 1'b1;
        rl  <= delta_low[RL_W-1:0];
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (upd) begin
          held <= vsel;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa <= phase_a;
      pb <= phase_b;
    end
    if (cmd.cal && !cal && cal_ok) begin
      span <= {delta, 1'b0};
    end
    if (cmd.start_a) begin
      band <= band_prod[RECIP_SHIFT +: BAND_W];
    end
    if (cmd.take_a) begin
      v1 <= q_sat;
    end
    if (cmd.take_b) begin
      v2 <= v2_wrap;
    end
    if (cmd.sel) begin
      vsel <= sel_v;
    end
    if (cmd.finish) begin
      position   <= upd ? vsel : held;
      changed    <= upd;
      calibrated <= cal;
    end
  end

  assign stat.calibrated = cal;
  assign stat.div_done   = div_done;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

[rtl/core/edp_ctrl.sv]
`timescale 1ns / 1ps

module edp_ctrl import edp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  edp_stat_t stat,
  output edp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CAL     = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_START_A = 4'd3;
  localparam logic [3:0] S_WAIT_A  = 4'd4;
  localparam logic [3:0] S_START_B = 4'd5;
  localparam logic [3:0] S_WAIT_B  = 4'd6;
  localparam logic [3:0] S_SEL     = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CAL;
        end
      end
      S_CAL: begin
        cmd.cal    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.calibrated ? S_START_A : S_FINISH;
      end
      S_START_A: begin
        cmd.start_a = 1'b1;
        state_next  = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (stat.div_done) begin
          cmd.take_a = 1'b1;
          state_next = S_START_B;
        end
      end
      S_START_B: begin
        cmd.start_b = 1'b1;
        state_next  = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (stat.div_done) begin
          cmd.take_b = 1'b1;
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/endless_pot_decoder_unit.sv]
`timescale 1ns / 1ps

// decoder for an endless potentiometer with two wipers a quarter turn apart.
// each input word carries one adc sample of each wiper; each one gives exactly
// one result word with the stored knob position, a changed flag and the
// calibrated flag. until a calibration succeeds, every sample is tried as a
// calibration pair (both samples away from the rails, wiper difference just
// above half scale); a rejected pair returns the held position (zero after
// reset) with changed low. once calibrated, both phases are scaled to full_scale
// positions by one shared 17-step restoring divider used twice in turn, and the
// next word is taken when that one is done. full_scale sits at byte address 0
// and hysteresis at 4 of the apb port; write them only while the decoder is
// idle. a full_scale below 2 acts as 2.
module endless_pot_decoder_unit import edp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  edp_in_if.sink            samples,
  edp_out_if.source         result
);

  // configuration registers
  logic [FS_W-1:0]   full_scale;
  logic [HYST_W-1:0] hysteresis;
  logic              reg_sel;
  logic              cfg_write;

  edp_cmd_t  dp_cmd;
  edp_stat_t dp_stat;

  // register index from the word address, byte lanes ignored
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RST;
      hysteresis <= HYST_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FULL_SCALE: full_scale <= pwdata[FS_W-1:0];
        REG_HYSTERESIS: hysteresis <= pwdata[HYST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FULL_SCALE: prdata = APB_DW'(full_scale);
      REG_HYSTERESIS: prdata = APB_DW'(hysteresis);
      default:        prdata = '0;
    endcase
  end

  // sequencer: calibrate, two divisions, select, hysteresis
  edp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // datapath with the divider and the result register
  edp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .phase_a    (samples.phase_a),
    .phase_b    (samples.phase_b),
    .full_scale (full_scale),
    .hysteresis (hysteresis),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .position   (result.position),
    .changed    (result.changed),
    .calibrated (result.calibrated)
  );

  // a sample word starts work, so the input closes on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("input still open after a word was taken");

  // calibration is one-shot and never lost
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    dp_stat.calibrated |=> dp_stat.calibrated)
    else $error("calibration dropped");

  // a change can only be reported by a calibrated decoder
  a_change_needs_cal: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.changed) |-> result.calibrated)
    else $error("change flagged while uncalibrated");

endmodule

[tb/edp_knob_checker.sv]
`timescale 1ns / 1ps

module edp_knob_checker import edp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  edp_in_if                 samples,
  edp_out_if                result,
  output int                mismatches,
  output int                pending_words
);

  typedef struct packed {
    logic [FS_W-1:0] position;
    logic            changed;
    logic            calibrated;
  } knob_word_t;

  knob_word_t  knob_due_q[$];
  int unsigned full_scale_reg;
  int unsigned hyst_reg;
  int unsigned low_end;   // magnitude of the negative low end
  int unsigned high_end;
  bit          cal_done;
  int unsigned held_pos;
  int          fail_count;

  function automatic int unsigned dist_of(input int unsigned x, input int unsigned y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic int unsigned scale_to_knob(input int unsigned p, input int unsigned fs,
                                                input int unsigned span);
    longint unsigned v;
    v = longint'(fs) * longint'(p + low_end) / longint'(span);
    return (v > 65535) ? 32'd65535 : 32'(v);
  endfunction

  // advances the decoder state by one sample pair and gives the word it should return
  function automatic knob_word_t decode_sample(input logic [ADC_W-1:0] a,
                                               input logic [ADC_W-1:0] b);
    int unsigned pa, pb, gap, fs, span, centre, band, v1, v2, pick;
    knob_word_t  w;
    pa = a;
    pb = b;
    w.changed = 1'b0;
    if (!cal_done && pa >= LO_RAIL && pa <= HI_RAIL && pb >= LO_RAIL && pb <= HI_RAIL) begin
      gap = dist_of(pa, pb);
      if (gap >= HALF && gap - HALF <= LOW_LIMIT) begin
        low_end  = gap - HALF;
        high_end = HALF + gap;
        cal_done = 1'b1;
      end
    end
    if (cal_done) begin
      fs     = (full_scale_reg < FS_MIN) ? FS_MIN : full_scale_reg;
      span   = high_end + low_end;
      centre = (high_end - low_end) / 2;
      band   = span / 10;
      v1     = scale_to_knob(pa, fs, span);
      v2     = (scale_to_knob(pb, fs, span) + fs / 2) % fs;
      if (dist_of(pa, centre) < band)
        pick = v1;
      else if (dist_of(pb, centre) < band)
        pick = v2;
      else
        pick = ((v1 + v2) / 2) % fs;
      if (dist_of(pick, held_pos) > hyst_reg) begin
        held_pos  = pick & 32'hFFFF;
        w.changed = 1'b1;
      end
    end
    w.position   = held_pos[FS_W-1:0];
    w.calibrated = cal_done;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    knob_word_t got, want;
    if (rst) begin
      knob_due_q.delete();
      full_scale_reg = FULL_SCALE_RST;
      hyst_reg       = HYST_RST;
      low_end        = 0;
      high_end       = 0;
      cal_done       = 1'b0;
      held_pos       = 0;
      fail_count     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_FULL_SCALE)
          full_scale_reg = pwdata[FS_W-1:0];
        else if (paddr[APB_AW-1:2] == REG_HYSTERESIS)
          hyst_reg = pwdata[HYST_W-1:0];
      end
      // results first: a word never leaves in the cycle its sample arrives
      if (result.valid && result.ready) begin
        got.position   = result.position;
        got.changed    = result.changed;
        got.calibrated = result.calibrated;
        if (knob_due_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected word pos %0d chg %0b cal %0b", $realtime,
                     got.position, got.changed, got.calibrated);
          fail_count++;
        end else begin
          want = knob_due_q.pop_front();
          if (got.position !== want.position || got.changed !== want.changed ||
              got.calibrated !== want.calibrated) begin
            if (fail_count < 10)
              $display("%0t: word mismatch, expected pos %0d chg %0b cal %0b, got pos %0d chg %0b cal %0b",
                       $realtime, want.position, want.changed, want.calibrated,
                       got.position, got.changed, got.calibrated);
            fail_count++;
          end
        end
      end
      if (samples.valid && samples.ready)
        knob_due_q.push_back(decode_sample(samples.phase_a, samples.phase_b));
    end
    mismatches    <= fail_count;
    pending_words <= knob_due_q.size();
  end

endmodule

[tb/endless_pot_decoder_unit_tb.sv]
`timescale 1ns / 1ps

module endless_pot_decoder_unit_tb;
  import edp_pkg::*;

  localparam int HOLD_CYCLES = 600;   // one long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles with nothing moving before giving up
  localparam int PHASE_WORDS = 183;   // sample words per configuration setting
  localparam int NUM_PHASES  = 10;
  localparam int IDLE_PCT    = 32;

  // flavours of random sample pairs
  typedef enum logic [1:0] {SWEEP, NEAR_CENTRE, RAIL_HIT, NOISE} sample_kind_e;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  int                mismatches;
  int                pending_words;
  bit                quiet;        // no idling on either side while set
  bit                hold_req;     // asks the receiver for its long hold-off
  int                stall_cycles;
  int unsigned       wiper_angle;  // knob angle of the sweep, 0..2047 per turn

  edp_in_if  samples_if ();
  edp_out_if result_if ();

  endless_pot_decoder_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_if),
    .result  (result_if)
  );

  edp_knob_checker knob_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .samples       (samples_if),
    .result        (result_if),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // triangle shape of one wiper over a full turn
  function automatic logic [ADC_W-1:0] tri_wave(input int unsigned angle);
    return (angle < 1024) ? ADC_W'(angle) : ADC_W'(2047 - angle);
  endfunction

  // apb write with a setup and an access phase, then psel is left low before
  // returning, so back-to-back writes never lower and raise psel in the same step
  task automatic apb_write(input logic reg_idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // junk in the unused upper bits checks that the registers mask them off
  task automatic write_config(input int unsigned fs, input int unsigned hy);
    logic [APB_DW-1:0] data;
    data = $urandom();
    data[FS_W-1:0] = fs[FS_W-1:0];
    apb_write(REG_FULL_SCALE, data);
    data = $urandom();
    data[HYST_W-1:0] = hy[HYST_W-1:0];
    apb_write(REG_HYSTERESIS, data);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain;
    samples_if.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // offer one sample word, with random idle cycles ahead of it
  task automatic send_word(input logic [ADC_W-1:0] a, input logic [ADC_W-1:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid   <= 1'b1;
    samples_if.phase_a <= a;
    samples_if.phase_b <= b;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // mostly a knob being turned to and fro, with centre hits, rails and noise mixed in
  task automatic random_pair(output logic [ADC_W-1:0] a, output logic [ADC_W-1:0] b);
    sample_kind_e kind;
    int unsigned  pick;
    pick = $urandom_range(99);
    kind = (pick < 65) ? SWEEP : (pick < 77) ? NEAR_CENTRE : (pick < 85) ? RAIL_HIT : NOISE;
    case (kind)
      SWEEP: begin
        wiper_angle = (wiper_angle + 2048 + $urandom_range(48) - 24) % 2048;
        a = tri_wave(wiper_angle);
        b = tri_wave((wiper_angle + 512) % 2048);
      end
      NEAR_CENTRE: begin
        // around the centre of the calibrated range, inside and just outside the band
        if ($urandom_range(1)) begin
          a = $urandom_range(641, 381);
          b = $urandom_range(1023);
        end else begin
          a = $urandom_range(1023);
          b = $urandom_range(641, 381);
        end
      end
      RAIL_HIT: begin
        a = $urandom_range(1) ? '1 : '0;
        b = $urandom_range(1) ? '1 : ADC_W'($urandom_range(1023));
      end
      default: begin
        a = $urandom_range(1023);
        b = $urandom_range(1023);
      end
    endcase
  endtask

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: any handshake or bus access counts as progress
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (result_if.valid && result_if.ready) ||
        psel)
      stall_cycles <= 0;
    else if (stall_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    // pairs refused as calibration: both rails, each sample just past a rail
    // with a good wiper gap, and wiper gaps just too small and just too large
    logic [ADC_W-1:0] reject_a [12] = '{0, 1023, 0, 1023, 101, 921, 700, 320, 200, 710, 200, 812};
    logic [ADC_W-1:0] reject_b [12] = '{0, 1023, 1023, 0, 700, 320, 101, 921, 710, 200, 812, 200};
    // after calibration: single phase a, single phase b, scaling past full
    // scale, both rails and the averaged path
    logic [ADC_W-1:0] decode_a [7]  = '{511, 800, 1023, 0, 1023, 600, 255};
    logic [ADC_W-1:0] decode_b [7]  = '{800, 511, 600, 0, 1023, 600, 255};
    int unsigned fs_set [6] = '{2, 0, 1, 32768, 65535, 1024};
    int unsigned hy_set [6] = '{0, 1, 0, 32767, 3, 4};
    int unsigned lo_gap, gap, base, fs, hy;
    logic [ADC_W-1:0] a, b;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    samples_if.valid   <= 1'b0;
    samples_if.phase_a <= '0;
    samples_if.phase_b <= '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    wiper_angle = $urandom_range(2047);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part runs on the reset values of the registers
    for (int i = 0; i < 12; i++)
      send_word(reject_a[i], reject_b[i]);

    // one-shot calibration, low end at zero, at its limit or anywhere between
    pick_gap: begin
      case ($urandom_range(2))
        0:       lo_gap = 0;
        1:       lo_gap = LOW_LIMIT;
        default: lo_gap = $urandom_range(LOW_LIMIT);
      endcase
      gap  = HALF + lo_gap;
      base = $urandom_range(HI_RAIL - gap, LO_RAIL);
      if ($urandom_range(1))
        send_word(ADC_W'(base), ADC_W'(base + gap));
      else
        send_word(ADC_W'(base + gap), ADC_W'(base));
    end

    for (int i = 0; i < 7; i++)
      send_word(decode_a[i], decode_b[i]);

    // random part: fixed extremes first, then random settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain;
      if (ph < 6) begin
        fs = fs_set[ph];
        hy = hy_set[ph];
      end else begin
        fs = $urandom_range(1) ? $urandom_range(64, 2) : $urandom_range(32768, 2);
        hy = $urandom_range(3) != 0 ? $urandom_range(8) : $urandom_range(32767);
      end
      write_config(fs, hy);
      quiet = (ph == 6);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long receiver stall with the sender still pushing
        if (ph == 3 && n == 60)
          hold_req = 1'b1;
        // sender pause until the pipe is empty
        if (ph == 5 && n == 90)
          drain;
        random_pair(a, b);
        send_word(a, b);
      end
    end

    drain;
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_words == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/edp_pkg.sv
rtl/core/edp_if.sv
rtl/core/edp_div.sv
rtl/core/edp_datapath.sv
rtl/core/edp_ctrl.sv
rtl/core/endless_pot_decoder_unit.sv
tb/edp_knob_checker.sv
tb/endless_pot_decoder_unit_tb.sv
